FILE: src/assert_macros.svh
// Assertion helpers for the tokenizer scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("tokenizer assertion failed");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("tokenizer forbidden condition");

`endif

FILE: src/st_pkg.sv
// ----------------------------------------------------------------------------
// st_pkg: shared types and constants of the source tokenizer
// Token record passed from the scanner to the finishing stage, token kinds,
// error codes and the keyword table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package st_pkg;

	localparam int KW_MAX_LEN = 9;
	localparam int KW_BITS    = 8 * KW_MAX_LEN;
	localparam int KW_COUNT   = 37;
	localparam int MAX_COMMENT_DEPTH = 15;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);

	localparam logic [19:0] LINE_MAX  = 20'hFFFFF;
	localparam logic [31:0] HASH_INIT = 32'h811C9DC5;
	localparam logic [31:0] HASH_MUL  = 32'd16777619;
	localparam logic [31:0] HASH_FIN  = 32'h85EBCA6B;

	localparam logic [5:0] K_EOF     = 6'd0;
	localparam logic [5:0] K_IDENT   = 6'd1;
	localparam logic [5:0] K_KEYWORD = 6'd2;
	localparam logic [5:0] K_STRING  = 6'd3;
	localparam logic [5:0] K_INT     = 6'd4;
	localparam logic [5:0] K_REAL    = 6'd5;
	localparam logic [5:0] K_PLUS    = 6'd6;
	localparam logic [5:0] K_MINUS   = 6'd7;
	localparam logic [5:0] K_TIMES   = 6'd8;
	localparam logic [5:0] K_SLASH   = 6'd9;
	localparam logic [5:0] K_TILDE   = 6'd10;
	localparam logic [5:0] K_OP_IN   = 6'd11;
	localparam logic [5:0] K_OP_IS   = 6'd12;
	localparam logic [5:0] K_OP_OR   = 6'd13;
	localparam logic [5:0] K_OP_DIV  = 6'd14;
	localparam logic [5:0] K_OP_MOD  = 6'd15;
	localparam logic [5:0] K_OP_BXOR = 6'd16;
	localparam logic [5:0] K_OP_BAND = 6'd17;
	localparam logic [5:0] K_OP_BOR  = 6'd18;
	localparam logic [5:0] K_AMP     = 6'd19;
	localparam logic [5:0] K_DOT     = 6'd20;
	localparam logic [5:0] K_COMMA   = 6'd21;
	localparam logic [5:0] K_SEMI    = 6'd22;
	localparam logic [5:0] K_BAR     = 6'd23;
	localparam logic [5:0] K_LPAREN  = 6'd24;
	localparam logic [5:0] K_RPAREN  = 6'd25;
	localparam logic [5:0] K_LBRACK  = 6'd26;
	localparam logic [5:0] K_RBRACK  = 6'd27;
	localparam logic [5:0] K_LBRACE  = 6'd28;
	localparam logic [5:0] K_RBRACE  = 6'd29;
	localparam logic [5:0] K_BECOMES = 6'd30;
	localparam logic [5:0] K_CARET   = 6'd31;
	localparam logic [5:0] K_EQUAL   = 6'd32;
	localparam logic [5:0] K_HASH    = 6'd33;
	localparam logic [5:0] K_LESS    = 6'd34;
	localparam logic [5:0] K_GREATER = 6'd35;
	localparam logic [5:0] K_LEQ     = 6'd36;
	localparam logic [5:0] K_GEQ     = 6'd37;
	localparam logic [5:0] K_UPTO    = 6'd38;
	localparam logic [5:0] K_COLON   = 6'd39;
	localparam logic [5:0] K_ERROR   = 6'd40;

	localparam logic [2:0] E_NONE     = 3'd0;
	localparam logic [2:0] E_HEX      = 3'd1;
	localparam logic [2:0] E_CHAR     = 3'd2;
	localparam logic [2:0] E_OPEN_STR = 3'd3;
	localparam logic [2:0] E_OPEN_COM = 3'd4;
	localparam logic [2:0] E_BAD_CHAR = 3'd5;

	// Keyword text, right-justified with zero bytes above.
	localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
		"ARRAY", "BEGIN", "BY", "CASE", "CONST", "DIV", "DO", "ELSE", "ELSIF",
		"END", "FALSE", "FOR", "IF", "IMPORT", "IN", "IS", "MOD", "MODULE",
		"NATIVE", "NIL", "OF", "OR", "POINTER", "PROCEDURE", "RECORD", "REPEAT",
		"RETURN", "THEN", "TO", "TRUE", "TYPE", "UNTIL", "VAR", "WHILE",
		"BITXOR", "BITAND", "BITOR"};

	localparam logic [5:0] KW_KIND [KW_COUNT] = '{
		K_KEYWORD, K_KEYWORD, K_KEYWORD, K_KEYWORD, K_KEYWORD, K_OP_DIV,
		K_KEYWORD, K_KEYWORD, K_KEYWORD, K_KEYWORD, K_KEYWORD, K_KEYWORD,
		K_KEYWORD, K_KEYWORD, K_OP_IN, K_OP_IS, K_OP_MOD, K_KEYWORD,
		K_KEYWORD, K_KEYWORD, K_KEYWORD, K_OP_OR, K_KEYWORD, K_KEYWORD,
		K_KEYWORD, K_KEYWORD, K_KEYWORD, K_KEYWORD, K_KEYWORD, K_KEYWORD,
		K_KEYWORD, K_KEYWORD, K_KEYWORD, K_KEYWORD, K_OP_BXOR, K_OP_BAND,
		K_OP_BOR};

	typedef enum logic [3:0] {
		M_IDLE, M_IDENT, M_NUM, M_NUMDOT, M_FRAC, M_EXPMARK, M_EXP,
		M_STR, M_COM, M_COMSTAR, M_COMPAR, M_OP
	} mode_t;

	typedef struct packed {
		logic [5:0]         kind;
		logic [31:0]        ival;
		logic [31:0]        hash;   // running hash, finished downstream
		logic [15:0]        len;
		logic [19:0]        line;
		logic [2:0]         err;
		logic               last;
		logic               fin;    // apply final hash mix
		logic               ident;  // look up in keyword table
		logic [KW_BITS-1:0] kwv;
	} tok_t;

endpackage

`default_nettype wire

FILE: src/st_front.sv
// ----------------------------------------------------------------------------
// st_front: byte scanner
// Takes one source byte per request, runs the lexer state machine one pass per
// cycle while the queue has room and pushes raw token records into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module st_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // char_in
	output logic             push_valid,
	input  wire logic        push_ready,
	output st_pkg::tok_t     push_tok
);
	import st_pkg::*;

	mode_t               mode_q, mode_d;
	logic                again;
	logic                busy_q, halted_q, halted_d;
	logic [7:0]          c;
	logic [31:0]         dec_q, dec_d, hex_q, hex_d, hash_q, hash_d;
	logic                hexl_q, hexl_d;
	logic [15:0]         cnt_q, cnt_d;
	logic [KW_BITS-1:0]  kwv_q, kwv_d;
	logic [19:0]         line_q, line_d, csl_q, csl_d, line_inc;
	logic [3:0]          depth_q, depth_d, depth_dn;
	logic [7:0]          held_q, held_d;
	logic                emit;
	tok_t                tok;

	logic is_let, is_dig, is_ws, is_hold, is_quote, is_hexl, idle_emits;
	logic [5:0]  sk;
	logic [3:0]  hexv;
	logic [31:0] mh, mres, digit;
	logic [7:0]  mc;
	logic [30:0] mx;
	logic        step;

	always_comb begin
		is_let   = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
		is_dig   = c >= "0" && c <= "9";
		is_ws    = c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
		is_hold  = c == "(" || c == ":" || c == "<" || c == ">" || c == ".";
		is_quote = c == 8'h22;
		is_hexl  = (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
		hexv     = 4'(c[2:0] + 3'd1) + 4'd8;   // letters A..F and a..f
		digit    = {28'd0, c[3:0]};
		idle_emits = !(is_ws || is_let || is_dig || is_quote || is_hold);
		case (c)
			"+": sk = K_PLUS;
			"-": sk = K_MINUS;
			"*": sk = K_TIMES;
			"/": sk = K_SLASH;
			"~": sk = K_TILDE;
			"&": sk = K_AMP;
			",": sk = K_COMMA;
			";": sk = K_SEMI;
			"|": sk = K_BAR;
			")": sk = K_RPAREN;
			"[": sk = K_LBRACK;
			"]": sk = K_RBRACK;
			"{": sk = K_LBRACE;
			"}": sk = K_RBRACE;
			"^": sk = K_CARET;
			"=": sk = K_EQUAL;
			"#": sk = K_HASH;
			default: sk = K_EOF;
		endcase
	end

	// One hash step shared by identifiers, strings and character constants.
	always_comb begin
		mh   = (mode_q == M_IDENT || mode_q == M_STR) ? hash_q : HASH_INIT;
		mc   = (mode_q == M_NUM) ? hex_q[7:0] : c;
		mx   = mh[30:0] ^ {23'd0, mc};
		mres = {1'b0, mx} * HASH_MUL;
	end

	assign line_inc = (line_q != LINE_MAX) ? line_q + 20'd1 : line_q;
	assign depth_dn = (depth_q != 4'd0) ? depth_q - 4'd1 : 4'd0;

	// next state
	always_comb begin
		mode_d = mode_q;
		again  = 1'b0;
		case (mode_q)
			M_IDLE: begin
				if (is_let)
					mode_d = M_IDENT;
				else if (is_dig)
					mode_d = M_NUM;
				else if (is_quote)
					mode_d = M_STR;
				else if (is_hold)
					mode_d = M_OP;
			end
			M_IDENT: begin
				if (!(is_let || is_dig)) begin
					mode_d = M_IDLE;
					again  = 1'b1;
				end
			end
			M_NUM: begin
				if (is_dig || is_hexl)
					mode_d = M_NUM;
				else if (c == "X" || c == "x" || c == "H" || c == "h")
					mode_d = M_IDLE;
				else if (c == ".")
					mode_d = M_NUMDOT;
				else if (hexl_q)
					mode_d = M_IDLE;
				else begin
					mode_d = M_IDLE;
					again  = 1'b1;
				end
			end
			M_NUMDOT: begin
				if (c == ".") begin
					if (hexl_q)
						mode_d = M_IDLE;
					else begin
						// finish as int, then rescan as ".."
						mode_d = M_OP;
						again  = 1'b1;
					end
				end else begin
					mode_d = M_FRAC;
					again  = 1'b1;
				end
			end
			M_FRAC, M_EXPMARK, M_EXP: begin
				if (is_dig) begin
					if (mode_q == M_EXPMARK)
						mode_d = M_EXP;
				end else if (mode_q == M_FRAC && (c == "e" || c == "E"))
					mode_d = M_EXPMARK;
				else if (mode_q != M_EXP && c == "-")
					mode_d = M_EXP;
				else begin
					mode_d = M_IDLE;
					again  = 1'b1;
				end
			end
			M_STR: begin
				if (is_quote || c == 8'd0)
					mode_d = M_IDLE;
			end
			M_COM, M_COMSTAR, M_COMPAR: begin
				if (c == 8'd0)
					mode_d = M_IDLE;
				else if (mode_q == M_COMSTAR && c == ")")
					mode_d = (depth_dn == 4'd0) ? M_IDLE : M_COM;
				else if (mode_q == M_COMPAR && c == "*")
					mode_d = M_COM;
				else if (c == "*")
					mode_d = M_COMSTAR;
				else if (c == "(")
					mode_d = M_COMPAR;
				else
					mode_d = M_COM;
			end
			M_OP: begin
				if (held_q == "(" && c == "*")
					mode_d = M_COM;
				else if (c == "=" && (held_q == ":" || held_q == "<" || held_q == ">"))
					mode_d = M_IDLE;
				else if (held_q == "." && c == ".")
					mode_d = M_IDLE;
				else begin
					mode_d = M_IDLE;
					again  = 1'b1;
				end
			end
			default: begin
				mode_d = M_IDLE;
				again  = 1'b1;
			end
		endcase
	end

	// outputs and data path
	always_comb begin
		dec_d = dec_q; hex_d = hex_q; hexl_d = hexl_q; hash_d = hash_q;
		cnt_d = cnt_q; kwv_d = kwv_q; line_d = line_q; csl_d = csl_q;
		depth_d = depth_q; held_d = held_q; halted_d = halted_q;
		emit = 1'b0;
		tok  = '0;
		tok.line = line_q;
		case (mode_q)
			M_IDLE: begin
				if (c == 8'd0) begin
					emit = 1'b1;
					tok.kind = K_EOF;
				end else if (is_ws) begin
					if (c == 8'h0A)
						line_d = line_inc;
				end else if (is_let) begin
					hash_d = mres;
					cnt_d  = 16'd1;
					kwv_d  = {{(KW_BITS-8){1'b0}}, c};
				end else if (is_dig) begin
					dec_d  = digit;
					hex_d  = digit;
					hexl_d = 1'b0;
				end else if (is_quote) begin
					hash_d = HASH_INIT;
					cnt_d  = 16'd0;
					kwv_d  = '0;
					csl_d  = line_q;
				end else if (is_hold)
					held_d = c;
				else if (sk != K_EOF) begin
					emit = 1'b1;
					tok.kind = sk;
				end else begin
					emit = 1'b1;
					halted_d = 1'b1;
					tok.kind = K_ERROR;
					tok.err  = E_BAD_CHAR;
				end
			end
			M_IDENT: begin
				if (is_let || is_dig) begin
					hash_d = mres;
					if (cnt_q < 16'(KW_MAX_LEN))
						kwv_d = {kwv_q[KW_BITS-9:0], c};
					if (cnt_q != 16'hFFFF)
						cnt_d = cnt_q + 16'd1;
				end else begin
					emit = 1'b1;
					tok.kind  = K_IDENT;
					tok.hash  = hash_q;
					tok.len   = cnt_q;
					tok.fin   = 1'b1;
					tok.ident = 1'b1;
					tok.kwv   = kwv_q;
				end
			end
			M_NUM: begin
				if (is_dig) begin
					dec_d = (dec_q << 3) + (dec_q << 1) + digit;
					hex_d = {hex_q[27:0], c[3:0]};
				end else if (is_hexl) begin
					hex_d  = {hex_q[27:0], hexv};
					hexl_d = 1'b1;
				end else if (c == "X" || c == "x") begin
					emit = 1'b1;
					if (hex_q > 32'd255) begin
						halted_d = 1'b1;
						tok.kind = K_ERROR;
						tok.err  = E_CHAR;
					end else begin
						tok.kind = K_STRING;
						tok.fin  = 1'b1;
						if (hex_q == 32'd0)
							tok.hash = HASH_INIT;
						else begin
							tok.ival = hex_q;
							tok.hash = mres;
							tok.len  = 16'd1;
						end
					end
				end else if (c == "H" || c == "h") begin
					emit = 1'b1;
					tok.kind = K_INT;
					tok.ival = hex_q;
				end else if (c == ".") begin
					emit = 1'b0;
				end else if (hexl_q) begin
					emit = 1'b1;
					halted_d = 1'b1;
					tok.kind = K_ERROR;
					tok.err  = E_HEX;
				end else begin
					emit = 1'b1;
					tok.kind = K_INT;
					tok.ival = dec_q;
				end
			end
			M_NUMDOT: begin
				if (c == ".") begin
					emit = 1'b1;
					if (hexl_q) begin
						halted_d = 1'b1;
						tok.kind = K_ERROR;
						tok.err  = E_HEX;
					end else begin
						tok.kind = K_INT;
						tok.ival = dec_q;
						held_d   = ".";
					end
				end
			end
			M_FRAC, M_EXPMARK, M_EXP: begin
				if (!(is_dig || (mode_q == M_FRAC && (c == "e" || c == "E"))
						|| (mode_q != M_EXP && c == "-"))) begin
					emit = 1'b1;
					tok.kind = K_REAL;
				end
			end
			M_STR: begin
				if (is_quote) begin
					emit = 1'b1;
					tok.kind = K_STRING;
					tok.hash = hash_q;
					tok.len  = cnt_q;
					tok.fin  = 1'b1;
				end else if (c == 8'd0) begin
					emit = 1'b1;
					halted_d = 1'b1;
					tok.kind = K_ERROR;
					tok.err  = E_OPEN_STR;
					tok.line = csl_q;
				end else begin
					if (c == 8'h0A)
						line_d = line_inc;
					hash_d = mres;
					if (cnt_q < 16'(KW_MAX_LEN))
						kwv_d = {kwv_q[KW_BITS-9:0], c};
					if (cnt_q != 16'hFFFF)
						cnt_d = cnt_q + 16'd1;
				end
			end
			M_COM, M_COMSTAR, M_COMPAR: begin
				if (c == 8'd0) begin
					emit = 1'b1;
					halted_d = 1'b1;
					tok.kind = K_ERROR;
					tok.err  = E_OPEN_COM;
					tok.line = csl_q;
				end else begin
					if (c == 8'h0A)
						line_d = line_inc;
					if (mode_q == M_COMSTAR && c == ")")
						depth_d = depth_dn;
					else if (mode_q == M_COMPAR && c == "*"
							&& depth_q < 4'(MAX_COMMENT_DEPTH))
						depth_d = depth_q + 4'd1;
				end
			end
			M_OP: begin
				held_d = 8'd0;
				if (held_q == "(" && c == "*") begin
					depth_d = 4'd1;
					csl_d   = line_q;
				end else begin
					emit = 1'b1;
					if (c == "=" && held_q == ":")
						tok.kind = K_BECOMES;
					else if (c == "=" && held_q == "<")
						tok.kind = K_LEQ;
					else if (c == "=" && held_q == ">")
						tok.kind = K_GEQ;
					else if (held_q == "." && c == ".")
						tok.kind = K_UPTO;
					else begin
						case (held_q)
							"(": tok.kind = K_LPAREN;
							":": tok.kind = K_COLON;
							"<": tok.kind = K_LESS;
							">": tok.kind = K_GREATER;
							default: tok.kind = K_DOT;
						endcase
					end
				end
			end
			default: emit = 1'b0;
		endcase
		// last unless the rescan of this byte emits again
		tok.last = !again || (mode_d == M_IDLE && !idle_emits);
	end

	assign s_tready   = !busy_q;
	assign push_valid = busy_q && emit;
	assign push_tok   = tok;
	assign step       = busy_q && (!emit || push_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			halted_q <= 1'b0;
			mode_q   <= M_IDLE;
			dec_q    <= '0;
			hex_q    <= '0;
			hexl_q   <= 1'b0;
			hash_q   <= HASH_INIT;
			cnt_q    <= '0;
			line_q   <= 20'd1;
			depth_q  <= '0;
			csl_q    <= 20'd1;
			held_q   <= '0;
		end else if (s_tvalid && s_tready) begin
			busy_q <= !halted_q;
		end else if (step) begin
			busy_q   <= again && !halted_d;
			halted_q <= halted_d;
			mode_q   <= halted_d ? M_IDLE : mode_d;
			dec_q    <= dec_d;
			hex_q    <= hex_d;
			hexl_q   <= hexl_d;
			hash_q   <= hash_d;
			cnt_q    <= cnt_d;
			line_q   <= line_d;
			depth_q  <= depth_d;
			csl_q    <= csl_d;
			held_q   <= held_d;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			c <= s_tdata;
		if (step)
			kwv_q <= kwv_d;
	end

	`ASSERT_CLK(a_halt_sticks, halted_q |=> halted_q)
	`ASSERT_NEVER(a_push_halted, push_valid && halted_q)
	`ASSERT_CLK(a_line_monotonic, 1'b1 |=> line_q >= $past(line_q))

endmodule

`default_nettype wire

FILE: src/st_queue.sv
// ----------------------------------------------------------------------------
// st_queue: token queue
// Short first-in first-out buffer between the scanner and finishing stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module st_queue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push_valid,
	output logic              push_ready,
	input  wire st_pkg::tok_t push_tok,
	output logic              pop_valid,
	input  wire logic         pop_ready,
	output st_pkg::tok_t      pop_tok
);
	import st_pkg::*;

	tok_t                mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_q, rd_q;
	logic [QPTR_W:0]     cnt_q;
	logic                do_push, do_pop;

	assign push_ready = cnt_q != (QPTR_W+1)'(QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_tok    = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_tok;
	end

endmodule

`default_nettype wire

FILE: src/st_back.sv
// ----------------------------------------------------------------------------
// st_back: token finishing stage
// Resolves keywords, applies the final hash mix over two stages and holds
// the result in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module st_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         pop_valid,
	output logic              pop_ready,
	input  wire st_pkg::tok_t pop_tok,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [119:0]      m_tdata,
	output logic              m_tlast
);
	import st_pkg::*;

	logic        s1_valid, out_valid_q, s2_ready;
	logic [5:0]  kind_s1, kwi_s1, kind_c, kwi_c;
	logic [31:0] ival_s1, hmul_s1, hash_fin;
	logic [15:0] len_s1;
	logic [19:0] line_s1;
	logic [2:0]  err_s1;
	logic        last_s1, fin_s1;
	logic [31:0] hmul_c;

	logic [5:0]  kind_q, kwi_q;
	logic [31:0] ival_q, hash_q;
	logic [15:0] len_q;
	logic [19:0] line_q;
	logic [2:0]  err_q;
	logic        last_q;

	always_comb begin
		kind_c = pop_tok.kind;
		kwi_c  = '0;
		if (pop_tok.ident && pop_tok.len <= 16'(KW_MAX_LEN)) begin
			for (int k = KW_COUNT - 1; k >= 0; k--) begin
				if (pop_tok.kwv == KW_TEXT[6'(k)]) begin
					kind_c = KW_KIND[6'(k)];
					kwi_c  = 6'(k);
				end
			end
		end
		hmul_c = pop_tok.hash * HASH_FIN;
	end

	assign s2_ready  = !out_valid_q || m_tready;
	assign pop_ready = !s1_valid || s2_ready;
	assign hash_fin  = fin_s1 ? (hmul_s1 ^ {16'd0, hmul_s1[31:16]}) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_ready)
				s1_valid <= pop_valid;
			if (s2_ready)
				out_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			kind_s1 <= kind_c;
			kwi_s1  <= kwi_c;
			ival_s1 <= pop_tok.ival;
			hmul_s1 <= hmul_c;
			len_s1  <= pop_tok.len;
			line_s1 <= pop_tok.line;
			err_s1  <= pop_tok.err;
			last_s1 <= pop_tok.last;
			fin_s1  <= pop_tok.fin;
		end
		if (s2_ready && s1_valid) begin
			kind_q <= kind_s1;
			kwi_q  <= kwi_s1;
			ival_q <= ival_s1;
			hash_q <= hash_fin;
			len_q  <= len_s1;
			line_q <= line_s1;
			err_q  <= err_s1;
			last_q <= last_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {5'd0, err_q, line_q, len_q, hash_q, kwi_q, ival_q, kind_q};

endmodule

`default_nettype wire

FILE: src/source_tokenizer.sv
// ----------------------------------------------------------------------------
// source_tokenizer: byte-serial lexer
// Scanner, token queue and finishing stage.
// ----------------------------------------------------------------------------
// Each source byte is first captured and then gets one lexer pass in the
// scanner, plus one more pass when the byte ends a pending token and is scanned
// again, and one more for the byte that follows the dot of a number; a token
// that finds the queue full holds the scanner until a slot frees up. Tokens
// wait in a four-entry queue and leave through a two-stage keyword/hash-finish
// pipe, so the scanner keeps taking bytes while results are stalled until the
// queue fills. An error token halts the block until reset; later bytes are
// taken and dropped.
`timescale 1ns / 1ps
`default_nettype none

module source_tokenizer (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // char_in
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// token_kind, int_value, keyword_index, text_hash, text_length,
	// line_number, error_code, zero pad
	output logic [119:0]      m_tdata,
	output logic              m_tlast    // last
);
	import st_pkg::*;

	logic push_valid, push_ready, pop_valid, pop_ready;
	tok_t push_tok, pop_tok;

	st_front u_front (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata,
		.push_valid, .push_ready, .push_tok
	);

	st_queue u_queue (
		.clk, .arst_n, .push_valid, .push_ready, .push_tok,
		.pop_valid, .pop_ready, .pop_tok
	);

	st_back u_back (
		.clk, .arst_n, .pop_valid, .pop_ready, .pop_tok,
		.m_tvalid, .m_tready, .m_tdata, .m_tlast
	);

endmodule

`default_nettype wire
